// ===== design/lcs_pkg.sv =====
// Shared types and codes for the longest common subsequence core.
package lcs_pkg;

  // Traceback direction codes stored in the direction table.
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_DIAG = 2'd3;

  // Input action codes.
  localparam logic [1:0] ACT_FIRST  = 2'd0;
  localparam logic [1:0] ACT_SECOND = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic       run;
    logic       second;
    logic [7:0] sym;
  } req_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FILL_RD = 7'b0000010,
    S_FILL_WR = 7'b0000100,
    S_TR_RD   = 7'b0001000,
    S_TR_EV   = 7'b0010000,
    S_EM_RD   = 7'b0100000,
    S_EM_LD   = 7'b1000000
  } state_t;

endpackage

// ===== design/lcs_front.sv =====
// Front part: accepts input requests, classifies them and queues them.
module lcs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_action,
  input  logic [7:0]    in_symbol,
  output logic          q_valid,
  output lcs_pkg::req_t q_req,
  input  logic          q_pop
);
  import lcs_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  req_t       req;

  assign in_ready = (fill_r != 2'd2);
  assign q_valid  = (fill_r != 2'd0);
  assign q_req    = slot_r[rd_ptr_r];

  always_comb begin
    req.run    = (in_action == ACT_RUN);
    req.second = (in_action == ACT_SECOND);
    req.sym    = in_symbol;
  end

  // drop unused action codes here
  assign push = in_valid && in_ready &&
                ((in_action == ACT_FIRST) || (in_action == ACT_SECOND) ||
                 (in_action == ACT_RUN));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== design/lcs_back.sv =====
// Back part: string storage, table fill, traceback and result output.
module lcs_back #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lcs_pkg::req_t q_req,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_symbol_res,
  output logic          out_has_symbol,
  output logic [6:0]    out_lcs_length,
  output logic          out_overflow,
  output logic          out_last
);
  import lcs_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  logic [7:0]    str1_mem [MAX_LEN];
  logic [7:0]    str2_mem [MAX_LEN];
  logic [CW-1:0] row_mem  [MAX_LEN];
  logic [1:0]    dir_mem  [2**(2*AW)];
  logic [7:0]    tb_mem   [MAX_LEN];

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt1_r, cnt2_r, fi_r, fj_r, ti_r, tj_r, tc_r, k_r, len_r;
  logic [CW-1:0] left_r, diag_r;
  logic          drop_r;
  logic [7:0]    s1_q, s2_q, tb_q;
  logic [CW-1:0] up_q;
  logic [1:0]    d_q;

  logic [AW-1:0] s1_addr;
  logic [CW-1:0] up, val;
  logic [1:0]    dir;
  logic          out_free, em_empty, em_last;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign em_empty = (tc_r == '0);
  assign em_last  = em_empty || (k_r + 1'b1 == tc_r);

  // cell update
  always_comb begin
    up = (fi_r == CW'(1)) ? '0 : up_q;
    if (s1_q == s2_q) begin
      val = diag_r + 1'b1;
      dir = DIR_DIAG;
    end else if (up >= left_r) begin
      val = up;
      dir = DIR_UP;
    end else begin
      val = left_r;
      dir = DIR_LEFT;
    end
  end

  assign s1_addr = (state_r == S_TR_RD) ? AW'(ti_r - 1'b1) : AW'(fi_r - 1'b1);

  // memories
  always_ff @(posedge clk) begin
    if (q_pop && !q_req.run && !q_req.second && cnt1_r < FULL)
      str1_mem[AW'(cnt1_r)] <= q_req.sym;
    if (q_pop && !q_req.run && q_req.second && cnt2_r < FULL)
      str2_mem[AW'(cnt2_r)] <= q_req.sym;
    s1_q <= str1_mem[s1_addr];
    s2_q <= str2_mem[AW'(fj_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FILL_WR) row_mem[AW'(fj_r - 1'b1)] <= val;
    up_q <= row_mem[AW'(fj_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FILL_WR)
      dir_mem[{AW'(fi_r - 1'b1), AW'(fj_r - 1'b1)}] <= dir;
    d_q <= dir_mem[{AW'(ti_r - 1'b1), AW'(tj_r - 1'b1)}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TR_EV && d_q == DIR_DIAG) tb_mem[AW'(tc_r)] <= s1_q;
    tb_q <= tb_mem[AW'(tc_r - k_r - 1'b1)];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (q_valid && q_req.run) begin
                   if (cnt1_r == '0 || cnt2_r == '0) state_nxt = S_TR_RD;
                   else state_nxt = S_FILL_RD;
                 end
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: if (fj_r == cnt2_r && fi_r == cnt1_r) state_nxt = S_TR_RD;
                 else state_nxt = S_FILL_RD;
      S_TR_RD:   if (ti_r == '0 || tj_r == '0) state_nxt = S_EM_RD;
                 else state_nxt = S_TR_EV;
      S_TR_EV:   state_nxt = S_TR_RD;
      S_EM_RD:   state_nxt = S_EM_LD;
      S_EM_LD:   if (out_free) state_nxt = em_last ? S_IDLE : S_EM_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt1_r    <= '0;
      cnt2_r    <= '0;
      drop_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EM_LD && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (q_valid && !q_req.run) begin
          if (!q_req.second) begin
            if (cnt1_r < FULL) cnt1_r <= cnt1_r + 1'b1;
            else drop_r <= 1'b1;
          end else begin
            if (cnt2_r < FULL) cnt2_r <= cnt2_r + 1'b1;
            else drop_r <= 1'b1;
          end
        end
        S_EM_LD: if (out_free && em_last) begin
          cnt1_r <= '0;
          cnt2_r <= '0;
          drop_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        fi_r   <= CW'(1);
        fj_r   <= CW'(1);
        left_r <= '0;
        diag_r <= '0;
        ti_r   <= cnt1_r;
        tj_r   <= cnt2_r;
        tc_r   <= '0;
        k_r    <= '0;
        len_r  <= '0;
      end
      S_FILL_WR: begin
        if (fj_r == cnt2_r) begin
          fi_r   <= fi_r + 1'b1;
          fj_r   <= CW'(1);
          left_r <= '0;
          diag_r <= '0;
          if (fi_r == cnt1_r) len_r <= val;
        end else begin
          fj_r   <= fj_r + 1'b1;
          left_r <= val;
          diag_r <= up;
        end
      end
      S_TR_EV: begin
        if (d_q == DIR_DIAG) begin
          tc_r <= tc_r + 1'b1;
          ti_r <= ti_r - 1'b1;
          tj_r <= tj_r - 1'b1;
        end else if (d_q == DIR_UP) begin
          ti_r <= ti_r - 1'b1;
        end else begin
          tj_r <= tj_r - 1'b1;
        end
      end
      S_EM_LD: if (out_free) begin
        out_symbol_res <= em_empty ? 8'd0 : tb_q;
        out_has_symbol <= !em_empty;
        out_lcs_length <= em_empty ? 7'd0 : 7'(len_r);
        out_overflow   <= drop_r;
        out_last       <= em_last;
        k_r            <= k_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/longest_common_subsequence_core.sv =====
// Top level of the longest common subsequence core.
//
// Input channel (in_valid/in_ready): each request carries in_action and
// in_symbol. Action 0 appends in_symbol to the first string, action 1 to
// the second, action 2 starts a run; action 3 is dropped. Each string holds
// up to MAX_LEN symbols; further appends are dropped and flagged in
// out_overflow of the next run's results.
// Result channel (out_valid/out_ready): a run returns the common
// subsequence first symbol to last, one result per symbol, each carrying
// the total length; out_last marks the final one. An empty subsequence
// gives one result with out_has_symbol low.
// Timing: a two-entry queue takes requests every cycle while the back end
// is idle; appends retire at one per cycle. A run fills the table with a
// read and a write state per cell, traces back with a read and an evaluate
// state per step, and sends each result with a read and a load state.
// When the receiver stalls, the result register holds and the back end
// waits; the queue keeps accepting until full.
// Reset clears the queue, string counts, drop flag and output valid; no
// clearing pass is needed.
module longest_common_subsequence_core #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol_res,
  output logic       out_has_symbol,
  output logic [6:0] out_lcs_length,
  output logic       out_overflow,
  output logic       out_last
);
  import lcs_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;

  // classify and buffer requests
  lcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_action(in_action),
    .in_symbol(in_symbol),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  // execute appends and runs
  lcs_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol_res(out_symbol_res),
    .out_has_symbol(out_has_symbol),
    .out_lcs_length(out_lcs_length),
    .out_overflow  (out_overflow),
    .out_last      (out_last)
  );

endmodule
